FILE: sv/tpsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpsc_pkg
// Shared constants, types and the station table for the tuner preset and
// step control block.
// ----------------------------------------------------------------------------
package tpsc_pkg;

  // Field and register widths
  localparam int FREQ_W  = 27;
  localparam int IF_W    = 25;
  localparam int STEP_W  = 20;
  localparam int TICK_W  = 8;
  localparam int CFG_W   = 27;
  localparam int CFG_IDX_W = 3;
  localparam int PNUM_W  = 3;

  // Preset slots and index width
  localparam int PRESET_SLOTS = 8;
  localparam int IDX_W = (PRESET_SLOTS > 1) ? $clog2(PRESET_SLOTS) : 1;
  localparam int TABLE_SIZE = 8;
  localparam int STATION_UNIT_HZ = 100000;

  // Reset values
  localparam logic [IF_W-1:0]   IF_RESET       = IF_W'(10700000);
  localparam logic [STEP_W-1:0] STEP_RESET     = STEP_W'(100000);
  localparam logic [FREQ_W-1:0] MIN_LO_RESET   = FREQ_W'(76800000);
  localparam logic [FREQ_W-1:0] MAX_LO_RESET   = FREQ_W'(97300000);
  localparam logic [TICK_W-1:0] DEBOUNCE_RESET = TICK_W'(50);
  localparam logic [FREQ_W-1:0] LO_RESET       = FREQ_W'(89800000);
  localparam logic [IDX_W-1:0]  PRESET_RESET   = (4 < PRESET_SLOTS) ? IDX_W'(4) : '0;
  localparam logic [IDX_W-1:0]  PRESET_LAST    = IDX_W'(PRESET_SLOTS - 1);
  localparam logic [TICK_W-1:0] COUNT_MAX      = '1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IF_FREQ  = 3'd0,
    CFG_STEP     = 3'd1,
    CFG_MIN_LO   = 3'd2,
    CFG_MAX_LO   = 3'd3,
    CFG_DEBOUNCE = 3'd4
  } cfg_reg_t;

  // Station frequency in hertz for a table slot
  function automatic logic [FREQ_W-1:0] station_hz(input logic [2:0] slot);
    logic [FREQ_W-1:0] hz;
    case (slot)
      3'd0:    hz = FREQ_W'(910  * STATION_UNIT_HZ);
      3'd1:    hz = FREQ_W'(912  * STATION_UNIT_HZ);
      3'd2:    hz = FREQ_W'(935  * STATION_UNIT_HZ);
      3'd3:    hz = FREQ_W'(983  * STATION_UNIT_HZ);
      3'd4:    hz = FREQ_W'(1005 * STATION_UNIT_HZ);
      3'd5:    hz = FREQ_W'(1018 * STATION_UNIT_HZ);
      3'd6:    hz = FREQ_W'(1030 * STATION_UNIT_HZ);
      default: hz = FREQ_W'(1064 * STATION_UNIT_HZ);
    endcase
    return hz;
  endfunction

endpackage

FILE: sv/tpsc_mode_debounce.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpsc_mode_debounce
// Stable-tick debouncer for the mode pin; flags a debounced press on the
// item where the pin level is accepted low.
// ----------------------------------------------------------------------------
module tpsc_mode_debounce import tpsc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic              mode_level,
  input  logic [TICK_W-1:0] debounce_ticks,
  output logic              press
);

  logic              last_mode_reading;
  logic              mode_stable_level;
  logic [TICK_W-1:0] stable_count;
  logic [TICK_W-1:0] stable_count_next;
  logic              accept_level;

  // Restart on a change, count up to saturation otherwise
  always_comb begin
    if (mode_level != last_mode_reading) begin
      stable_count_next = '0;
    end else if (stable_count != COUNT_MAX) begin
      stable_count_next = stable_count + TICK_W'(1);
    end else begin
      stable_count_next = stable_count;
    end
  end

  assign accept_level = (stable_count_next > debounce_ticks) &&
                        (mode_level != mode_stable_level);
  assign press = accept_level && !mode_level;

  // Update debounce state once per item
  always_ff @(posedge clk) begin
    if (rst) begin
      last_mode_reading <= 1'b1;
      mode_stable_level <= 1'b1;
      stable_count      <= '0;
    end else if (advance) begin
      last_mode_reading <= mode_level;
      stable_count      <= stable_count_next;
      if (accept_level) begin
        mode_stable_level <= mode_level;
      end
    end
  end

endmodule

FILE: sv/tuner_preset_and_step_control.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tuner_preset_and_step_control
// Button-driven tuning control: preset stepping over a station table or
// direct stepping with clamping, plus a debounced mode toggle.
// ----------------------------------------------------------------------------
// Pipeline: an accepted item passes the input register, then the result
// register; the state update happens as the item enters the result register.
// Throughput: one item per cycle while the receiver does not stall; the
// single input-to-result stage sets it.
// Reset: synchronous, clears both pipeline valids and loads the tuning state
// and configuration registers with their power-on values.
// ----------------------------------------------------------------------------
module tuner_preset_and_step_control import tpsc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 plus_level,
  input  logic                 minus_level,
  input  logic                 mode_level,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [FREQ_W-1:0]    lo_freq_hz,
  output logic                 direct_mode,
  output logic [PNUM_W-1:0]    preset_number,
  output logic                 retune,
  // configuration
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // Configuration registers
  logic [IF_W-1:0]   if_offset_hz;
  logic [STEP_W-1:0] step_hz;
  logic [FREQ_W-1:0] min_lo_hz;
  logic [FREQ_W-1:0] max_lo_hz;
  logic [TICK_W-1:0] debounce_ticks;

  // Input register
  logic in_reg_valid;
  logic in_plus, in_minus, in_mode;
  logic advance;

  // Tuning state
  logic              prev_plus, prev_minus;
  logic              direct_flag, direct_flag_next;
  logic [IDX_W-1:0]  preset_idx, preset_idx_next;
  logic [FREQ_W-1:0] lo_freq, lo_freq_next;
  logic              retune_next;

  logic              step_up, step_down;
  logic              mode_press;
  logic [FREQ_W:0]   cand;
  logic              cand_neg;
  logic [FREQ_W-1:0] preset_hz;
  logic [IDX_W+2:0]  idx_ext;
  logic [IDX_W+2:0]  idx_next_ext;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      if_offset_hz    <= IF_RESET;
      step_hz         <= STEP_RESET;
      min_lo_hz       <= MIN_LO_RESET;
      max_lo_hz       <= MAX_LO_RESET;
      debounce_ticks  <= DEBOUNCE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_IF_FREQ:  if_offset_hz    <= cfg_data[IF_W-1:0];
        CFG_STEP:     step_hz         <= cfg_data[STEP_W-1:0];
        CFG_MIN_LO:   min_lo_hz       <= cfg_data[FREQ_W-1:0];
        CFG_MAX_LO:   max_lo_hz       <= cfg_data[FREQ_W-1:0];
        CFG_DEBOUNCE: debounce_ticks  <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the stage moves when the result register is free
  assign advance  = in_reg_valid && (!out_valid || !out_stall);
  assign in_stall = in_reg_valid && !advance;

  // Capture the input item
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_plus  <= plus_level;
      in_minus <= minus_level;
      in_mode  <= mode_level;
    end
  end

  // Edge detect; minus wins when both fall
  assign step_down = !in_minus && prev_minus;
  assign step_up   = !in_plus && prev_plus && !step_down;

  // Direct step candidate with sign of the result
  always_comb begin
    if (step_up) begin
      cand     = (FREQ_W+1)'(lo_freq) + (FREQ_W+1)'(step_hz);
      cand_neg = 1'b0;
    end else begin
      cand     = (FREQ_W+1)'(lo_freq) - (FREQ_W+1)'(step_hz);
      cand_neg = lo_freq < FREQ_W'(step_hz);
    end
  end

  // Wrap the preset index
  always_comb begin
    if (step_up) begin
      preset_idx_next = (preset_idx >= PRESET_LAST) ? '0 : preset_idx + IDX_W'(1);
    end else begin
      preset_idx_next = (preset_idx == '0 || preset_idx > PRESET_LAST) ?
                        PRESET_LAST : preset_idx - IDX_W'(1);
    end
  end

  assign idx_ext      = (IDX_W+3)'(preset_idx);
  assign idx_next_ext = (IDX_W+3)'(preset_idx_next);
  assign preset_hz    = station_hz(idx_next_ext[2:0]);

  // Mode debouncer
  tpsc_mode_debounce u_mode_debounce (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .mode_level     (in_mode),
    .debounce_ticks (debounce_ticks),
    .press          (mode_press)
  );

  // Next tuning state
  always_comb begin
    lo_freq_next     = lo_freq;
    direct_flag_next = direct_flag ^ mode_press;
    retune_next      = mode_press;
    if (step_up || step_down) begin
      retune_next = 1'b1;
      if (direct_flag) begin
        if (!cand_neg && cand > (FREQ_W+1)'(max_lo_hz)) begin
          lo_freq_next = max_lo_hz;
        end else if (cand_neg || cand < (FREQ_W+1)'(min_lo_hz)) begin
          lo_freq_next = min_lo_hz;
        end else begin
          lo_freq_next = cand[FREQ_W-1:0];
        end
      end else begin
        lo_freq_next = (preset_hz >= FREQ_W'(if_offset_hz)) ?
                       preset_hz - FREQ_W'(if_offset_hz) : '0;
      end
    end
  end

  // Advance tuning state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_plus   <= 1'b1;
      prev_minus  <= 1'b1;
      direct_flag <= 1'b0;
      preset_idx  <= PRESET_RESET;
      lo_freq     <= LO_RESET;
    end else if (advance) begin
      prev_plus   <= in_plus;
      prev_minus  <= in_minus;
      direct_flag <= direct_flag_next;
      lo_freq     <= lo_freq_next;
      if ((step_up || step_down) && !direct_flag) begin
        preset_idx <= preset_idx_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      lo_freq_hz    <= lo_freq_next;
      direct_mode   <= direct_flag_next;
      preset_number <= ((step_up || step_down) && !direct_flag) ?
                       idx_next_ext[PNUM_W-1:0] : idx_ext[PNUM_W-1:0];
      retune        <= retune_next;
    end
  end

endmodule

FILE: verif/tuner_preset_and_step_control_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tuner_preset_and_step_control_tb
// Self-checking bench for the tuner control block. Button samples are sent one
// item per tick, a local model predicts every result, and a checker compares
// each result field by field. The bench covers preset stepping, direct
// stepping with clamping, and the debounced mode toggle, under random
// register settings and random idling on both channels.
// ----------------------------------------------------------------------------
module tuner_preset_and_step_control_tb;
  import tpsc_pkg::*;

  // A quiet stretch this long means the block has hung. The longest correct
  // gap is the forced receiver hold-off, PRESSURE_HOLD, plus sender idling.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PRESSURE_HOLD  = 300;
  localparam int unsigned FULL_IF   = (1 << IF_W) - 1;
  localparam int unsigned FULL_FREQ = (1 << FREQ_W) - 1;
  localparam int unsigned FULL_STEP = (1 << STEP_W) - 1;

  typedef struct packed {
    logic [FREQ_W-1:0] lo;
    logic              direct;
    logic [PNUM_W-1:0] pnum;
    logic              retune;
  } tuning_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 plus_level = 1'b1;
  logic                 minus_level = 1'b1;
  logic                 mode_level = 1'b1;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [FREQ_W-1:0]    lo_freq_hz;
  logic                 direct_mode;
  logic [PNUM_W-1:0]    preset_number;
  logic                 retune;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  tuner_preset_and_step_control dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .plus_level    (plus_level),
    .minus_level   (minus_level),
    .mode_level    (mode_level),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .lo_freq_hz    (lo_freq_hz),
    .direct_mode   (direct_mode),
    .preset_number (preset_number),
    .retune        (retune),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Station table in 100 kHz units
  int unsigned station_100khz [8] = '{910, 912, 935, 983, 1005, 1018, 1030, 1064};

  // Register shadows
  logic [IF_W-1:0]   cfg_if;
  logic [STEP_W-1:0] cfg_step;
  logic [FREQ_W-1:0] cfg_min;
  logic [FREQ_W-1:0] cfg_max;
  logic [TICK_W-1:0] cfg_deb;

  // Tuning state of the model
  logic              btn_plus_q, btn_minus_q, mode_raw_q, mode_accepted;
  logic [TICK_W-1:0] mode_run;
  logic              tuned_direct;
  int unsigned       tuned_slot;
  logic [FREQ_W-1:0] tuned_lo;

  tuning_t expected_tuning_q [$];
  tuning_t want, got;
  int      mismatches = 0;
  int      ticks_sent = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  int      quiet_cycles = 0;
  int      hold_left = 0;
  bit      pressure_req = 1'b0;
  logic    cur_mode = 1'b1;

  // Load power-on values into the model
  task automatic reset_model();
    cfg_if        = IF_W'(10700000);
    cfg_step      = STEP_W'(100000);
    cfg_min       = FREQ_W'(76800000);
    cfg_max       = FREQ_W'(97300000);
    cfg_deb       = TICK_W'(50);
    btn_plus_q    = 1'b1;
    btn_minus_q   = 1'b1;
    mode_raw_q    = 1'b1;
    mode_accepted = 1'b1;
    mode_run      = '0;
    tuned_direct  = 1'b0;
    tuned_slot    = (4 < PRESET_SLOTS) ? 4 : 0;
    tuned_lo      = FREQ_W'(89800000);
  endtask

  // Advance the model by one tick and queue the result it gives
  task automatic predict_tuning(input logic p, input logic m, input logic md);
    int      dir;
    logic    rt;
    longint  lo_l, step_l, nv, rf, ifq;
    tuning_t r;
    dir = 0;
    rt  = 1'b0;
    if (!p && btn_plus_q) dir = 1;
    btn_plus_q = p;
    if (!m && btn_minus_q) dir = -1;
    btn_minus_q = m;

    if (dir != 0) begin
      rt = 1'b1;
      if (tuned_direct) begin
        lo_l   = tuned_lo;
        step_l = cfg_step;
        nv = (dir > 0) ? lo_l + step_l : lo_l - step_l;
        // max is tested first, so an inverted range favors max
        if (nv > longint'(cfg_max)) tuned_lo = cfg_max;
        else if (nv < longint'(cfg_min)) tuned_lo = cfg_min;
        else tuned_lo = FREQ_W'(nv);
      end else begin
        if (dir > 0) begin
          tuned_slot = (tuned_slot + 1 >= PRESET_SLOTS) ? 0 : tuned_slot + 1;
        end else begin
          tuned_slot = (tuned_slot == 0 || tuned_slot > PRESET_SLOTS) ?
                       PRESET_SLOTS - 1 : tuned_slot - 1;
        end
        rf  = longint'(station_100khz[tuned_slot % 8]) * 100000;
        ifq = cfg_if;
        tuned_lo = (rf >= ifq) ? FREQ_W'(rf - ifq) : '0;
      end
    end

    // Debounce the mode pin; a press toggles the mode
    if (md != mode_raw_q) mode_run = '0;
    else if (mode_run != '1) mode_run = mode_run + 1'b1;
    if (mode_run > cfg_deb && md != mode_accepted) begin
      mode_accepted = md;
      if (!md) begin
        tuned_direct = ~tuned_direct;
        rt = 1'b1;
      end
    end
    mode_raw_q = md;

    r.lo     = tuned_lo;
    r.direct = tuned_direct;
    r.pnum   = PNUM_W'(tuned_slot);
    r.retune = rt;
    expected_tuning_q.push_back(r);
  endtask

  // Offer one item and hold it until accepted
  task automatic send_tick(input logic p, input logic m, input logic md);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    plus_level  <= p;
    minus_level <= m;
    mode_level  <= md;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_tuning(p, m, md);
    ticks_sent++;
  endtask

  // Drop valid and drain every outstanding result
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_tuning_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_reg(input cfg_reg_t idx, input int unsigned value);
    logic [CFG_W-1:0] v;
    v = CFG_W'(value);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_IF_FREQ:  cfg_if   = v[IF_W-1:0];
      CFG_STEP:     cfg_step = v[STEP_W-1:0];
      CFG_MIN_LO:   cfg_min  = v[FREQ_W-1:0];
      CFG_MAX_LO:   cfg_max  = v[FREQ_W-1:0];
      CFG_DEBOUNCE: cfg_deb  = v[TICK_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_profile(input int sender_pct, input int receiver_pct);
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
  endtask

  // Hold the mode pin while plus and minus chatter at random
  task automatic hold_mode(input logic lvl, input int ticks);
    cur_mode = lvl;
    repeat (ticks) send_tick($urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0, lvl);
  endtask

  // Mode hold length: mostly long enough to pass the debounce, sometimes not
  function automatic int hold_ticks();
    if ($urandom_range(0, 3) == 0) return $urandom_range(1, int'(cfg_deb) + 1);
    return int'(cfg_deb) + 1 + $urandom_range(0, 3);
  endfunction

  // One random button gesture
  task automatic play_gesture();
    logic p, m;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        repeat ($urandom_range(1, 3)) send_tick(1'b0, 1'b1, cur_mode);
        repeat ($urandom_range(1, 2)) send_tick(1'b1, 1'b1, cur_mode);
      end
      3, 4: begin
        repeat ($urandom_range(1, 3)) send_tick(1'b1, 1'b0, cur_mode);
        repeat ($urandom_range(1, 2)) send_tick(1'b1, 1'b1, cur_mode);
      end
      5: begin
        repeat ($urandom_range(1, 2)) send_tick(1'b0, 1'b0, cur_mode);
        send_tick(1'b1, 1'b1, cur_mode);
      end
      6, 7: begin
        hold_mode(1'b0, hold_ticks());
        hold_mode(1'b1, hold_ticks());
      end
      default: begin
        repeat ($urandom_range(1, 4)) begin
          p = 1'($urandom_range(0, 1));
          m = 1'($urandom_range(0, 1));
          cur_mode = 1'($urandom_range(0, 1));
          send_tick(p, m, cur_mode);
        end
      end
    endcase
  endtask

  task automatic run_random(input int n_items);
    int start;
    start = ticks_sent;
    while (ticks_sent - start < n_items) play_gesture();
  endtask

  // Pick a fresh setting for every register
  task automatic random_config();
    int unsigned a, b, t;
    case ($urandom_range(0, 3))
      0:       set_reg(CFG_IF_FREQ, 0);
      1:       set_reg(CFG_IF_FREQ, FULL_IF);
      default: set_reg(CFG_IF_FREQ, $urandom_range(0, 20000000));
    endcase
    case ($urandom_range(0, 4))
      0:       set_reg(CFG_STEP, 1);
      1:       set_reg(CFG_STEP, 1000000);
      2:       set_reg(CFG_STEP, FULL_STEP);
      default: set_reg(CFG_STEP, $urandom_range(1, 200000));
    endcase
    case ($urandom_range(0, 5))
      0: begin
        a = 0;
        b = FULL_FREQ;
      end
      1: begin
        a = $urandom_range(0, 100000000);
        b = $urandom_range(0, 100000000);
        if (a < b) begin
          t = a;
          a = b;
          b = t;
        end
      end
      2: begin
        a = $urandom_range(0, 100000000);
        b = $urandom_range(0, 100000000);
        if (a > b) begin
          t = a;
          a = b;
          b = t;
        end
      end
      default: begin
        // narrow window so clamping is frequent
        a = $urandom_range(60000000, 100000000);
        b = a + $urandom_range(0, 5000000);
      end
    endcase
    set_reg(CFG_MIN_LO, a);
    set_reg(CFG_MAX_LO, b);
    case ($urandom_range(0, 6))
      0, 1, 2, 3: set_reg(CFG_DEBOUNCE, $urandom_range(0, 4));
      4, 5:       set_reg(CFG_DEBOUNCE, $urandom_range(5, 40));
      default:    set_reg(CFG_DEBOUNCE, 0);
    endcase
  endtask

  // ---- tests ----

  task automatic test_power_on();
    send_tick(1'b1, 1'b1, 1'b1);
  endtask

  // Wrap upward past the last slot, downward past slot zero, minus beats plus
  task automatic test_preset_stepping();
    set_reg(CFG_IF_FREQ, 0);
    repeat (4) begin
      send_tick(1'b0, 1'b1, 1'b1);
      send_tick(1'b1, 1'b1, 1'b1);
    end
    set_reg(CFG_IF_FREQ, FULL_IF);
    send_tick(1'b1, 1'b0, 1'b1);
    send_tick(1'b1, 1'b1, 1'b1);
    send_tick(1'b0, 1'b0, 1'b1);
    send_tick(1'b1, 1'b1, 1'b1);
  endtask

  // Enter direct mode, clamp to max, go below zero, step with no effect
  task automatic test_direct_clamping();
    set_reg(CFG_DEBOUNCE, 0);
    set_reg(CFG_STEP, 1000000);
    set_reg(CFG_MIN_LO, 0);
    set_reg(CFG_MAX_LO, 50000);
    send_tick(1'b1, 1'b1, 1'b0);
    send_tick(1'b1, 1'b1, 1'b0);
    send_tick(1'b0, 1'b1, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b1);
    send_tick(1'b1, 1'b0, 1'b1);
    send_tick(1'b1, 1'b1, 1'b1);
  endtask

  // Min above max: above max gives max, below min gives min
  task automatic test_inverted_range();
    set_reg(CFG_MIN_LO, 100000000);
    set_reg(CFG_MAX_LO, 0);
    send_tick(1'b0, 1'b1, 1'b1);
    send_tick(1'b1, 1'b0, 1'b1);
    set_reg(CFG_MAX_LO, FULL_FREQ);
    set_reg(CFG_STEP, 1);
    send_tick(1'b0, 1'b1, 1'b1);
    send_tick(1'b1, 1'b1, 1'b1);
  endtask

  // A debounce of 255 never accepts a new mode level
  task automatic test_debounce_ceiling();
    set_reg(CFG_DEBOUNCE, 255);
    repeat (3) send_tick(1'b1, 1'b1, 1'b0);
    send_tick(1'b1, 1'b1, 1'b1);
    cur_mode = 1'b1;
  endtask

  task automatic test_random_settings();
    repeat (4) begin
      random_config();
      run_random(90);
    end
  endtask

  // Receiver holds off while the sender keeps offering items
  task automatic test_backpressure();
    int saved;
    saved = send_idle_pct;
    send_idle_pct = 0;
    pressure_req = 1'b1;
    run_random(60);
    send_idle_pct = saved;
  endtask

  // Largest regular debounce: a press must last 256 ticks
  task automatic test_long_debounce();
    set_reg(CFG_DEBOUNCE, 254);
    hold_mode(1'b0, 256);
    hold_mode(1'b1, 257);
  endtask

  // ---- result checking and receiver idling ----

  task automatic report_field(input string name, input logic [FREQ_W-1:0] exp_v,
                              input logic [FREQ_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      got.lo     = lo_freq_hz;
      got.direct = direct_mode;
      got.pnum   = preset_number;
      got.retune = retune;
      if (expected_tuning_q.size() == 0) begin
        $display("%0t: unexpected item expected none actual lo_freq_hz %0d",
                 $time, got.lo);
        mismatches++;
      end else begin
        want = expected_tuning_q.pop_front();
        report_field("lo_freq_hz", want.lo, got.lo);
        report_field("direct_mode", want.direct, got.direct);
        report_field("preset_number", want.pnum, got.pnum);
        report_field("retune", want.retune, got.retune);
      end
    end
    if (pressure_req) begin
      hold_left = PRESSURE_HOLD;
      pressure_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Watchdog: count cycles in which neither channel moves an item
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tuner_preset_and_step_control regression: fail");
      $finish;
    end
  end

  initial begin
    reset_model();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_profile(18, 46);
    test_power_on();
    test_preset_stepping();
    test_direct_clamping();
    test_inverted_range();
    test_debounce_ceiling();
    test_random_settings();

    set_profile(46, 18);
    test_backpressure();
    test_random_settings();

    set_profile(0, 0);
    test_random_settings();
    test_long_debounce();

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tuner_preset_and_step_control regression: pass");
    end else begin
      $display("tuner_preset_and_step_control regression: fail");
    end
    $finish;
  end

endmodule
